// ----- hw/rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Operation codes carried on the kind input
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

endpackage

// ----- hw/rtl/binary_max_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Priority queue of signed 32-bit values kept as a binary max-heap in a RAM.
// ----------------------------------------------------------------------------
// Raise start with kind and value while busy is low; the operation is taken
// on that edge and busy stays high until the result has been issued. Each
// operation gives one result, shown on max_value, entry_count, is_empty and
// op_error for exactly one cycle with done high; the receiver cannot stall
// it. Every step of a sift goes through the single heap RAM, one read
// or one write a cycle, plus one signed compare per climb step and two per
// sink step. An insert climbs level by level until it reaches the root or a
// parent that is not smaller; a remove moves the last entry into the root's
// place and sinks it until it has no larger child (about 10 levels at the
// default capacity of 1024). A refused operation (insert when full, remove
// when empty) and a remove that empties the heap skip the sift and go
// straight to the result. The RAM needs no clearing after reset.
module binary_max_heap_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic signed [bmhq_pkg::DATA_W-1:0] value,
  output logic                            done,
  output logic signed [bmhq_pkg::DATA_W-1:0] max_value,
  output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
  output logic                            is_empty,
  output logic                            op_error
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int IW = AW + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_LAST_RD = 4'd3;
  localparam logic [3:0] S_LAST    = 4'd4;
  localparam logic [3:0] S_DN_L    = 4'd5;
  localparam logic [3:0] S_DN_R    = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;
  localparam logic [3:0] S_RES     = 4'd9;

  data_t            mem [CAPACITY];
  data_t            rdata;

  logic [3:0]       state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    pos, pos_next;
  data_t            val, val_next;
  data_t            root, root_next;
  data_t            lval, lval_next;
  logic             has_r, has_r_next;
  logic             err, err_next;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  data_t            wr_data;

  logic [AW-1:0]    parent;
  logic [IW-1:0]    left_ix, right_ix;
  logic             left_ok, right_ok;
  logic             take_l, take_r;
  data_t            cand;

  assign parent   = (pos - 1'b1) >> 1;
  assign left_ix  = {1'b0, pos, 1'b1};
  assign right_ix = {1'b0, pos, 1'b0} + IW'(2);
  assign left_ok  = left_ix < IW'(count);
  assign right_ok = right_ix < IW'(count);
  assign take_l   = lval > val;
  assign cand     = take_l ? lval : val;
  assign take_r   = has_r && (rdata > cand);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    val_next   = val;
    root_next  = root;
    lval_next  = lval;
    has_r_next = has_r;
    err_next   = err;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_data    = val;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          err_next = 1'b0;
          if (kind == KIND_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              err_next   = 1'b1;
              state_next = S_RES;
            end else begin
              pos_next   = AW'(count);
              val_next   = value;
              count_next = count + 1'b1;
              state_next = (count == '0) ? S_FIN : S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              err_next   = 1'b1;
              state_next = S_RES;
            end else begin
              count_next = count - 1'b1;
              state_next = (count == CW'(1)) ? S_RES : S_LAST_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        rd_en      = 1'b1;
        rd_addr    = parent;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        // move a smaller parent down into the hole and climb
        if (rdata < val) begin
          wr_en      = 1'b1;
          wr_data    = rdata;
          pos_next   = parent;
          state_next = (parent == '0) ? S_FIN : S_UP_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_LAST_RD: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(count);
        state_next = S_LAST;
      end
      S_LAST: begin
        val_next   = rdata;
        pos_next   = '0;
        state_next = S_DN_L;
      end
      S_DN_L: begin
        if (left_ok) begin
          rd_en      = 1'b1;
          rd_addr    = left_ix[AW-1:0];
          state_next = S_DN_R;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DN_R: begin
        lval_next  = rdata;
        has_r_next = right_ok;
        rd_en      = right_ok;
        rd_addr    = right_ix[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        // left child wins a tie; a child rises only when strictly larger
        if (take_r || take_l) begin
          wr_en      = 1'b1;
          wr_data    = take_r ? rdata : lval;
          if (pos == '0) begin
            root_next = wr_data;
          end
          pos_next   = take_r ? right_ix[AW-1:0] : left_ix[AW-1:0];
          state_next = S_DN_L;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        wr_en   = 1'b1;
        wr_data = val;
        if (pos == '0) begin
          root_next = val;
        end
        state_next = S_RES;
      end
      S_RES: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == S_RES);
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    val   <= val_next;
    root  <= root_next;
    lval  <= lval_next;
    has_r <= has_r_next;
    err   <= err_next;
    if (state == S_RES) begin
      max_value   <= (count == '0) ? '0 : root;
      entry_count <= count;
      is_empty    <= (count == '0);
      op_error    <= err;
    end
  end

endmodule

// ----- hw/rtl/bmhq_checker.sv -----
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
module bmhq_checker #(
  parameter int CNT_W = 11
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic signed [bmhq_pkg::DATA_W-1:0] max_value,
  input logic [CNT_W-1:0]                   entry_count,
  input logic                               is_empty,
  input logic                               op_error
);
  import bmhq_pkg::*;

  // an accepted transfer always raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while still busy");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (max_value == '0))
    else $error("empty heap reports nonzero maximum");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

bind binary_max_heap_queue bmhq_checker #(
  .CNT_W($clog2(CAPACITY+1))
) u_bmhq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .max_value   (max_value),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .op_error    (op_error)
);

// ----- sim/tb_binary_max_heap_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue
// Self-checking bench for the binary max-heap priority queue. A queue of
// insert and remove commands feeds a clocked driver; a clocked monitor checks
// every result against a behavioral heap kept in the bench. The stimulus
// covers empty, single-entry and full heaps, value extremes and ties, and
// random sender gaps.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue;
  import bmhq_pkg::*;

  localparam int CAPACITY    = 1024;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDLE_PCT    = 17;
  localparam int RANDOM_OPS  = 120;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic  kind;
    data_t value;
  } heap_op_t;

  typedef struct {
    data_t            max_value;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
    logic             op_error;
  } heap_status_t;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  logic             kind  = KIND_INSERT;
  data_t            value = '0;
  logic             busy;
  logic             done;
  data_t            max_value;
  logic [CNT_W-1:0] entry_count;
  logic             is_empty;
  logic             op_error;

  heap_op_t     pending_ops[$];
  heap_status_t expected_status_q[$];
  heap_op_t     next_op;
  heap_status_t want;

  // Behavioral heap contents, updated at each accepted transfer
  data_t heap_mem[CAPACITY];
  int    heap_fill     = 0;
  int    planned_fill  = 0;
  int    accepted_cnt  = 0;
  int    mismatch_cnt  = 0;
  int    cycle_cnt     = 0;

  binary_max_heap_queue #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .value      (value),
    .done       (done),
    .max_value  (max_value),
    .entry_count(entry_count),
    .is_empty   (is_empty),
    .op_error   (op_error)
  );

  always #2 clk = ~clk;

  function automatic heap_status_t apply_heap_op(logic op, data_t val);
    heap_status_t r;
    int           pos;
    int           parent;
    int           left;
    int           best;
    data_t        tmp;
    r.op_error = 1'b0;
    if (op == KIND_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        r.op_error = 1'b1;
      end else begin
        pos = heap_fill;
        heap_mem[pos] = val;
        heap_fill++;
        // climb while the parent is strictly smaller
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_mem[parent] >= heap_mem[pos]) break;
          tmp = heap_mem[parent];
          heap_mem[parent] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = parent;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.op_error = 1'b1;
      end else begin
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        pos = 0;
        // sink toward the larger child, left wins a tie
        while (1) begin
          left = 2 * pos + 1;
          best = pos;
          if (left < heap_fill && heap_mem[best] < heap_mem[left]) best = left;
          if (left + 1 < heap_fill && heap_mem[best] < heap_mem[left + 1]) best = left + 1;
          if (best == pos) break;
          tmp = heap_mem[best];
          heap_mem[best] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = best;
        end
      end
    end
    r.max_value   = (heap_fill > 0) ? heap_mem[0] : data_t'(0);
    r.entry_count = CNT_W'(heap_fill);
    r.is_empty    = (heap_fill == 0);
    return r;
  endfunction

  // Queue a command and track the fill level it leaves behind
  task automatic queue_op(logic op, data_t val);
    heap_op_t item;
    item.kind  = op;
    item.value = val;
    pending_ops.push_back(item);
    if (op == KIND_INSERT && planned_fill < CAPACITY) planned_fill++;
    if (op == KIND_REMOVE && planned_fill > 0) planned_fill--;
  endtask

  function automatic data_t pick_value();
    int sel;
    int offs;
    sel  = $urandom_range(0, 9);
    offs = $urandom_range(0, 6);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return data_t'(offs - 3);               // dense ties around zero
      3: return data_t'(32'h8000_0000 + offs);
      4: return data_t'(32'h7FFF_FFFF - offs);
      default: return data_t'($urandom());
    endcase
  endfunction

  // Driver: hold an offered command until busy drops, then offer the next
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_status_q.push_back(apply_heap_op(kind, value));
        accepted_cnt++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_ops.size() != 0 &&
                   ((accepted_cnt >= 400 && accepted_cnt < 700) ||
                    $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_op = pending_ops.pop_front();
        start <= 1'b1;
        kind  <= next_op.kind;
        value <= next_op.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_status_q.size() == 0) begin
        $error("result with no transfer pending: max_value %0d entry_count %0d",
               max_value, entry_count);
        mismatch_cnt++;
      end else begin
        want = expected_status_q.pop_front();
        if (max_value !== want.max_value) begin
          $error("max_value: expected %0d, got %0d", want.max_value, max_value);
          mismatch_cnt++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
          mismatch_cnt++;
        end
        if (is_empty !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, is_empty);
          mismatch_cnt++;
        end
        if (op_error !== want.op_error) begin
          $error("op_error: expected %0b, got %0b", want.op_error, op_error);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_binary_max_heap_queue: errors");
      $finish;
    end
  end

  initial begin
    int budget;
    int bias;
    int len;
    int i;

    // Directed: empty heap, value extremes, ties, draining to empty
    queue_op(KIND_REMOVE, 32'h0000_0000);
    queue_op(KIND_INSERT, 32'h0000_0000);
    queue_op(KIND_REMOVE, 32'h0000_0000);
    queue_op(KIND_REMOVE, 32'hFFFF_FFFF);
    queue_op(KIND_INSERT, 32'h8000_0000);
    queue_op(KIND_INSERT, 32'h7FFF_FFFF);
    queue_op(KIND_INSERT, 32'hFFFF_FFFF);
    queue_op(KIND_INSERT, 32'h0000_0001);
    queue_op(KIND_INSERT, 32'h7FFF_FFFF);
    queue_op(KIND_INSERT, 32'h8000_0000);
    queue_op(KIND_REMOVE, 32'hFFFF_FFFF);
    queue_op(KIND_REMOVE, 32'h5555_5555);
    queue_op(KIND_REMOVE, 32'hAAAA_AAAA);
    queue_op(KIND_REMOVE, 32'h0000_0000);
    queue_op(KIND_REMOVE, 32'h0000_0000);
    queue_op(KIND_REMOVE, 32'h0000_0000);
    queue_op(KIND_REMOVE, 32'h7FFF_FFFF);
    // ascending inserts climb all the way to the root
    for (i = 1; i <= 8; i++) queue_op(KIND_INSERT, data_t'(i));

    // Random episodes, each with its own insert bias so the heap grows,
    // shrinks and runs dry
    budget = RANDOM_OPS;
    while (budget > 0) begin
      case ($urandom_range(0, 4))
        0: bias = 92;
        1: bias = 75;
        2: bias = 50;
        3: bias = 25;
        default: bias = 8;
      endcase
      len = $urandom_range(15, 70);
      for (i = 0; i < len && budget > 0; i++) begin
        if ($urandom_range(0, 99) < bias) queue_op(KIND_INSERT, pick_value());
        else queue_op(KIND_REMOVE, data_t'($urandom()));
        budget--;
      end
    end

    // Fill to capacity, push past it, then churn at the top
    while (planned_fill < CAPACITY) begin
      if ($urandom_range(0, 99) < 3) queue_op(KIND_REMOVE, data_t'($urandom()));
      else queue_op(KIND_INSERT, pick_value());
    end
    repeat (4) queue_op(KIND_INSERT, pick_value());
    repeat (6) begin
      queue_op(KIND_REMOVE, data_t'($urandom()));
      queue_op(KIND_INSERT, pick_value());
      queue_op(KIND_INSERT, pick_value());
    end
    repeat (8) queue_op(KIND_REMOVE, data_t'($urandom()));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || start || expected_status_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("tb_binary_max_heap_queue: clean");
    end else begin
      $display("tb_binary_max_heap_queue: errors");
    end
    $finish;
  end

endmodule
